[hw/rtl/gbn_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants of the Go-Back-N sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

   localparam int SEQ_W  = 3;
   localparam int CNT_W  = 3;
   localparam int DATA_W = 32;
   localparam int TICK_W = 16;

   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd500;

   // operating modes
   localparam logic [1:0] MODE_ACK   = 2'd0;
   localparam logic [1:0] MODE_NACK  = 2'd1;
   localparam logic [1:0] MODE_PIGGY = 2'd2;

   // register index (byte address bit 2)
   localparam logic REG_MODE    = 1'b0;
   localparam logic REG_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      OP_SEND = 2'd0,
      OP_ACK  = 2'd1,
      OP_TICK = 2'd2
   } gbn_op_type;

   typedef enum logic [1:0] {
      KIND_SENT   = 2'd0,
      KIND_RESENT = 2'd1,
      KIND_FULL   = 2'd2,
      KIND_STATUS = 2'd3
   } gbn_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RESEND,
      ST_DRAIN
   } gbn_state_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [TICK_W-1:0] timeout;
   } gbn_cfg_type;

   typedef struct packed {
      logic              strobe;
      gbn_kind_type      kind;
      logic [SEQ_W-1:0]  seq;
      logic [SEQ_W-1:0]  ack;
      logic [DATA_W-1:0] data;
      logic [SEQ_W-1:0]  base;
      logic [CNT_W-1:0]  in_flight;
      logic              all_acked;
      logic              last;
   } gbn_rsp_type;

endpackage
`default_nettype wire

[hw/rtl/go_back_n_sender.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// go_back_n_sender
// Go-Back-N ARQ sender with a circular window frame store.
// ----------------------------------------------------------------------------
// Input channel: an item (req_op send / ack-nack / tick) is taken at a clock
// edge with start high and busy low. Result words appear on the rsp_ ports
// for one cycle each, marked by rsp_strobe; rsp_last flags the final word of
// an item. The receiver cannot stall, so no word is ever held back.
// A send, an ack, or a tick that does not time out gives one word in the
// cycle after acceptance, and the next item can be taken in that same cycle:
// one item per cycle.
// A nack in mode 1, or a timeout, resends n stored frames (n up to WINDOW).
// The frames are read from the store one per cycle; the single read port of
// the store sets the pace. Each frame is read in ST_RESEND into the store's
// read register, with pend_ff beside it, and goes out through the rsp
// register; busy stays high through ST_RESEND and ST_DRAIN. Reset clears
// the window, timer and registers (mode 0, timeout 500); the store needs no
// clearing since only outstanding entries are ever read. The user writes
// configuration through the csr port only while idle; this is not enforced.
// ----------------------------------------------------------------------------
module go_back_n_sender #(
   parameter int WINDOW       = 4,
   parameter int SEQ_SPACE    = 8,
   parameter int PAYLOAD_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_op,
   input  wire logic [gbn_pkg::DATA_W-1:0]    req_data,
   input  wire logic [gbn_pkg::SEQ_W-1:0]     req_piggy_ack,
   input  wire logic [gbn_pkg::SEQ_W-1:0]     req_ack_num,
   input  wire logic                          req_is_nack,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_kind,
   output logic [gbn_pkg::SEQ_W-1:0]          rsp_frame_seq,
   output logic [gbn_pkg::SEQ_W-1:0]          rsp_frame_ack,
   output logic [gbn_pkg::DATA_W-1:0]         rsp_frame_data,
   output logic [gbn_pkg::SEQ_W-1:0]          rsp_base_seq,
   output logic [gbn_pkg::CNT_W-1:0]          rsp_in_flight,
   output logic                               rsp_all_acked,
   output logic                               rsp_last,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [2:0]                    paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int MEM_W  = PAYLOAD_BITS + gbn_pkg::SEQ_W;

   logic [1:0]                  mode_ff;
   logic [gbn_pkg::TICK_W-1:0]  timeout_ff;
   logic                        csr_wr;
   gbn_pkg::gbn_cfg_type        cfg;
   gbn_pkg::gbn_rsp_type        rsp;

   logic                        wr_en;
   logic [SLOT_W-1:0]           wr_addr;
   logic [MEM_W-1:0]            wr_data;
   logic                        rd_en;
   logic [SLOT_W-1:0]           rd_addr;
   logic [MEM_W-1:0]            rd_data;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= gbn_pkg::MODE_ACK;
         timeout_ff <= gbn_pkg::TIMEOUT_RESET;
      end else if (csr_wr) begin
         case (paddr[2])
            gbn_pkg::REG_MODE:    mode_ff    <= pwdata[1:0];
            gbn_pkg::REG_TIMEOUT: timeout_ff <= pwdata[gbn_pkg::TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         gbn_pkg::REG_MODE:    prdata = {30'd0, mode_ff};
         gbn_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_ff};
         default:              prdata = '0;
      endcase
   end

   assign cfg.mode    = mode_ff;
   assign cfg.timeout = timeout_ff;

   gbn_ctrl #(
      .WINDOW       (WINDOW),
      .SEQ_SPACE    (SEQ_SPACE),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .SLOT_W       (SLOT_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_data      (req_data),
      .req_piggy_ack (req_piggy_ack),
      .req_ack_num   (req_ack_num),
      .req_is_nack   (req_is_nack),
      .cfg           (cfg),
      .rsp           (rsp),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data)
   );

   gbn_store #(
      .DEPTH (WINDOW),
      .AW    (SLOT_W),
      .DW    (MEM_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_strobe     = rsp.strobe;
   assign rsp_kind       = rsp.kind;
   assign rsp_frame_seq  = rsp.seq;
   assign rsp_frame_ack  = rsp.ack;
   assign rsp_frame_data = rsp.data;
   assign rsp_base_seq   = rsp.base;
   assign rsp_in_flight  = rsp.in_flight;
   assign rsp_all_acked  = rsp.all_acked;
   assign rsp_last       = rsp.last;

endmodule
`default_nettype wire

[hw/rtl/gbn_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_store
// Window frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gbn_store #(
   parameter int DEPTH = 4,
   parameter int AW    = 2,
   parameter int DW    = 35
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

[hw/rtl/gbn_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_ctrl
// Window bookkeeping, timer and resend sequencer around the frame store.
// ----------------------------------------------------------------------------
module gbn_ctrl #(
   parameter int WINDOW       = 4,
   parameter int SEQ_SPACE    = 8,
   parameter int PAYLOAD_BITS = 32,
   parameter int SLOT_W       = 2
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [1:0]                           req_op,
   input  wire logic [gbn_pkg::DATA_W-1:0]           req_data,
   input  wire logic [gbn_pkg::SEQ_W-1:0]            req_piggy_ack,
   input  wire logic [gbn_pkg::SEQ_W-1:0]            req_ack_num,
   input  wire logic                                 req_is_nack,
   input  wire gbn_pkg::gbn_cfg_type                 cfg,
   output gbn_pkg::gbn_rsp_type                      rsp,
   output logic                                      wr_en,
   output logic [SLOT_W-1:0]                         wr_addr,
   output logic [PAYLOAD_BITS+gbn_pkg::SEQ_W-1:0]    wr_data,
   output logic                                      rd_en,
   output logic [SLOT_W-1:0]                         rd_addr,
   input  wire logic [PAYLOAD_BITS+gbn_pkg::SEQ_W-1:0] rd_data
);

   localparam logic [3:0] SEQ_SP = 4'(SEQ_SPACE);
   localparam logic [3:0] WIN4   = 4'(WINDOW);
   localparam logic [2:0] WIN3   = 3'(WINDOW);

   gbn_pkg::gbn_state_type state_ff, state_in;

   logic [gbn_pkg::SEQ_W-1:0]  base_ff, base_in;
   logic [gbn_pkg::SEQ_W-1:0]  nseq_ff, nseq_in;
   logic [gbn_pkg::CNT_W-1:0]  outst_ff, outst_in;
   logic [SLOT_W-1:0]          head_ff, head_in;
   logic                       timer_on_ff, timer_on_in;
   logic [gbn_pkg::TICK_W-1:0] tick_ff, tick_in;
   logic                       sent_any_ff, sent_any_in;
   logic [gbn_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic                       pend_ff, pend_in;
   logic [gbn_pkg::SEQ_W-1:0]  pend_seq_ff, pend_seq_in;
   logic                       pend_last_ff, pend_last_in;
   gbn_pkg::gbn_rsp_type       rsp_ff, rsp_in;

   logic                       accept;
   logic                       ack_ok;
   logic [gbn_pkg::SEQ_W-1:0]  off;
   logic                       off_hit;
   logic [gbn_pkg::CNT_W-1:0]  adv;
   logic [gbn_pkg::SEQ_W-1:0]  fa;
   logic [PAYLOAD_BITS-1:0]    pay;
   logic                       go_resend;
   logic                       issue_last;

   function automatic logic [gbn_pkg::SEQ_W-1:0] seq_wrap(input logic [3:0] v);
      logic [3:0] t;
      t = v;
      for (int k = 0; k < 8; k++) begin
         if (t >= SEQ_SP) begin
            t = t - SEQ_SP;
         end
      end
      return t[gbn_pkg::SEQ_W-1:0];
   endfunction

   // physical slot of window offset i
   function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] h,
                                                 input logic [2:0] i);
      logic [3:0] s;
      s = 4'(h) + 4'(i);
      if (s >= WIN4) begin
         s = s - WIN4;
      end
      return s[SLOT_W-1:0];
   endfunction

   assign accept  = start && (state_ff == gbn_pkg::ST_IDLE);
   assign busy    = (state_ff != gbn_pkg::ST_IDLE);
   assign ack_ok  = (4'(req_ack_num) < SEQ_SP);
   assign off     = seq_wrap(4'(req_ack_num) + SEQ_SP - 4'(base_ff));
   assign off_hit = ack_ok && (off < outst_ff);
   assign adv     = off + 3'd1;
   assign fa      = (cfg.mode == gbn_pkg::MODE_PIGGY) ? req_piggy_ack : '0;
   assign pay     = req_data[PAYLOAD_BITS-1:0];
   assign issue_last = ((idx_ff + 3'd1) == outst_ff);

   always_comb begin
      go_resend = 1'b0;
      if (gbn_pkg::gbn_op_type'(req_op) == gbn_pkg::OP_ACK) begin
         go_resend = (cfg.mode == gbn_pkg::MODE_NACK) && req_is_nack && off_hit;
      end else if (gbn_pkg::gbn_op_type'(req_op) == gbn_pkg::OP_TICK) begin
         go_resend = timer_on_ff && (tick_ff >= cfg.timeout) && (outst_ff != '0);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gbn_pkg::ST_IDLE: begin
            if (accept && go_resend) begin
               state_in = gbn_pkg::ST_RESEND;
            end
         end
         gbn_pkg::ST_RESEND: begin
            if (issue_last) begin
               state_in = gbn_pkg::ST_DRAIN;
            end
         end
         gbn_pkg::ST_DRAIN: begin
            state_in = gbn_pkg::ST_IDLE;
         end
         default: begin
            state_in = gbn_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      base_in      = base_ff;
      nseq_in      = nseq_ff;
      outst_in     = outst_ff;
      head_in      = head_ff;
      timer_on_in  = timer_on_ff;
      tick_in      = tick_ff;
      sent_any_in  = sent_any_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pend_seq_in  = pend_seq_ff;
      pend_last_in = pend_last_ff;
      rsp_in       = '0;
      rsp_in.kind  = gbn_pkg::KIND_STATUS;
      wr_en        = 1'b0;
      wr_addr      = slot_of(head_ff, outst_ff);
      wr_data      = {fa, pay};
      rd_en        = 1'b0;
      rd_addr      = slot_of(head_ff, idx_ff);

      case (state_ff)
         gbn_pkg::ST_IDLE: begin
            if (accept) begin
               case (gbn_pkg::gbn_op_type'(req_op))
                  gbn_pkg::OP_SEND: begin
                     if (outst_ff < WIN3) begin
                        wr_en       = 1'b1;
                        if (outst_ff == '0) begin
                           timer_on_in = 1'b1;
                           tick_in     = '0;
                        end
                        rsp_in.kind = gbn_pkg::KIND_SENT;
                        rsp_in.seq  = nseq_ff;
                        rsp_in.ack  = fa;
                        rsp_in.data = gbn_pkg::DATA_W'(pay);
                        nseq_in     = seq_wrap(4'(nseq_ff) + 4'd1);
                        outst_in    = outst_ff + 3'd1;
                        sent_any_in = 1'b1;
                     end else begin
                        rsp_in.kind = gbn_pkg::KIND_FULL;
                     end
                  end
                  gbn_pkg::OP_ACK: begin
                     if (go_resend) begin
                        idx_in = off;
                     end else if (off_hit && !((cfg.mode == gbn_pkg::MODE_NACK)
                                              && req_is_nack)) begin
                        base_in  = seq_wrap(4'(base_ff) + 4'(adv));
                        head_in  = slot_of(head_ff, adv);
                        outst_in = outst_ff - adv;
                        if (outst_ff != adv) begin
                           timer_on_in = 1'b1;
                           tick_in     = '0;
                        end else begin
                           timer_on_in = 1'b0;
                        end
                     end
                  end
                  gbn_pkg::OP_TICK: begin
                     if (timer_on_ff) begin
                        if (tick_ff >= cfg.timeout) begin
                           tick_in = '0;
                           idx_in  = '0;
                        end else begin
                           tick_in = tick_ff + 16'd1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               if (!go_resend) begin
                  rsp_in.strobe    = 1'b1;
                  rsp_in.last      = 1'b1;
                  rsp_in.base      = base_in;
                  rsp_in.in_flight = outst_in;
                  rsp_in.all_acked = sent_any_in && (outst_in == '0);
               end
            end
         end
         gbn_pkg::ST_RESEND: begin
            rd_en        = 1'b1;
            pend_in      = 1'b1;
            pend_seq_in  = seq_wrap(4'(base_ff) + 4'(idx_ff));
            pend_last_in = issue_last;
            idx_in       = idx_ff + 3'd1;
         end
         gbn_pkg::ST_DRAIN: begin
         end
         default: begin
         end
      endcase

      // read data of the previous cycle goes out as a resent frame
      if (pend_ff) begin
         rsp_in.strobe    = 1'b1;
         rsp_in.kind      = gbn_pkg::KIND_RESENT;
         rsp_in.seq       = pend_seq_ff;
         rsp_in.ack       = rd_data[PAYLOAD_BITS +: gbn_pkg::SEQ_W];
         rsp_in.data      = gbn_pkg::DATA_W'(rd_data[PAYLOAD_BITS-1:0]);
         rsp_in.base      = base_ff;
         rsp_in.in_flight = outst_ff;
         rsp_in.all_acked = sent_any_ff && (outst_ff == '0);
         rsp_in.last      = pend_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbn_pkg::ST_IDLE;
         base_ff      <= '0;
         nseq_ff      <= '0;
         outst_ff     <= '0;
         head_ff      <= '0;
         timer_on_ff  <= 1'b0;
         tick_ff      <= '0;
         sent_any_ff  <= 1'b0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         pend_seq_ff  <= '0;
         pend_last_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         nseq_ff      <= nseq_in;
         outst_ff     <= outst_in;
         head_ff      <= head_in;
         timer_on_ff  <= timer_on_in;
         tick_ff      <= tick_in;
         sent_any_ff  <= sent_any_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         pend_seq_ff  <= pend_seq_in;
         pend_last_ff <= pend_last_in;
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

`ifndef SYNTH
   a_outst_max: assert property (@(posedge clock) disable iff (reset)
      outst_ff <= WIN3)
      else $error("outstanding count exceeds window");

   a_timer_needs_frames: assert property (@(posedge clock) disable iff (reset)
      timer_on_ff |-> (outst_ff != '0))
      else $error("timer running with empty window");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ff.strobe && (rsp_ff.kind != gbn_pkg::KIND_RESENT)) |-> rsp_ff.last)
      else $error("non-resend word without last");

   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gbn_pkg::ST_DRAIN) |=> (rsp_ff.strobe && rsp_ff.last))
      else $error("resend burst did not end with last word");

   a_pend_busy: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff != gbn_pkg::ST_IDLE))
      else $error("pending read while idle");
`endif

endmodule
`default_nettype wire
